FILE: hw/rtl/rtc_pkg.sv
// Package with the widths, types and micro-program of the closest-hit unit.
`timescale 1ns / 1ps
`default_nettype none
package rtc_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int TAG_W     = 32;
  localparam int NW        = COORD_W + 1;       // edge and direction width
  localparam int CW        = 2 * NW + 1;        // cross product width
  localparam int AW        = NW + CW + 4;       // dot product accumulator width
  localparam int QW        = FRAC_BITS + 1;     // quantised result width
  localparam int CNT_W     = $clog2(NW + QW);
  localparam int NOPS      = 24;
  localparam int OP_W      = $clog2(NOPS);
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);
  localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

  // Operand selects of the shared multiplier.
  localparam logic [4:0] SEL_D0  = 5'd0;
  localparam logic [4:0] SEL_D1  = 5'd1;
  localparam logic [4:0] SEL_D2  = 5'd2;
  localparam logic [4:0] SEL_E10 = 5'd3;
  localparam logic [4:0] SEL_E11 = 5'd4;
  localparam logic [4:0] SEL_E12 = 5'd5;
  localparam logic [4:0] SEL_E20 = 5'd6;
  localparam logic [4:0] SEL_E21 = 5'd7;
  localparam logic [4:0] SEL_E22 = 5'd8;
  localparam logic [4:0] SEL_TV0 = 5'd9;
  localparam logic [4:0] SEL_TV1 = 5'd10;
  localparam logic [4:0] SEL_TV2 = 5'd11;
  localparam logic [4:0] SEL_PV0 = 5'd12;
  localparam logic [4:0] SEL_PV1 = 5'd13;
  localparam logic [4:0] SEL_PV2 = 5'd14;
  localparam logic [4:0] SEL_QV0 = 5'd15;
  localparam logic [4:0] SEL_QV1 = 5'd16;
  localparam logic [4:0] SEL_QV2 = 5'd17;

  // Destinations written at the end of a product group.
  localparam logic [3:0] DST_PV0  = 4'd0;
  localparam logic [3:0] DST_PV1  = 4'd1;
  localparam logic [3:0] DST_PV2  = 4'd2;
  localparam logic [3:0] DST_QV0  = 4'd3;
  localparam logic [3:0] DST_QV1  = 4'd4;
  localparam logic [3:0] DST_QV2  = 4'd5;
  localparam logic [3:0] DST_DET  = 4'd6;
  localparam logic [3:0] DST_U    = 4'd7;
  localparam logic [3:0] DST_V    = 4'd8;
  localparam logic [3:0] DST_T    = 4'd9;
  localparam logic [3:0] DST_NONE = 4'd10;

  // Quotient being formed.
  localparam logic [1:0] DIV_T = 2'd0;
  localparam logic [1:0] DIV_U = 2'd1;
  localparam logic [1:0] DIV_V = 2'd2;

  localparam logic CMD_RAY = 1'b0;

  typedef struct packed {
    logic       cmd;
    logic       last;
    logic [TAG_W-1:0] tag;
    logic [2:0][COORD_W-1:0] pa;  // ray origin or vertex a
    logic [2:0][NW-1:0] q1;       // direction or edge b - a
    logic [2:0][NW-1:0] q2;       // edge c - a
  } item_t;

  typedef struct packed {
    logic [4:0] a_sel;
    logic [4:0] b_sel;
    logic       sub;
    logic       first;
    logic [3:0] dst;
  } op_t;

  function automatic op_t mk(logic [4:0] a, logic [4:0] b, logic s, logic f,
                             logic [3:0] d);
    op_t o;
    o.a_sel = a;
    o.b_sel = b;
    o.sub   = s;
    o.first = f;
    o.dst   = d;
    return o;
  endfunction

  // Micro-program: both cross products, then the four dot products.
  function automatic op_t op_rom(logic [OP_W-1:0] idx);
    op_t o;
    unique case (idx)
      5'd0:    o = mk(SEL_D1,  SEL_E22, 1'b0, 1'b1, DST_NONE);
      5'd1:    o = mk(SEL_D2,  SEL_E21, 1'b1, 1'b0, DST_PV0);
      5'd2:    o = mk(SEL_D2,  SEL_E20, 1'b0, 1'b1, DST_NONE);
      5'd3:    o = mk(SEL_D0,  SEL_E22, 1'b1, 1'b0, DST_PV1);
      5'd4:    o = mk(SEL_D0,  SEL_E21, 1'b0, 1'b1, DST_NONE);
      5'd5:    o = mk(SEL_D1,  SEL_E20, 1'b1, 1'b0, DST_PV2);
      5'd6:    o = mk(SEL_TV1, SEL_E12, 1'b0, 1'b1, DST_NONE);
      5'd7:    o = mk(SEL_TV2, SEL_E11, 1'b1, 1'b0, DST_QV0);
      5'd8:    o = mk(SEL_TV2, SEL_E10, 1'b0, 1'b1, DST_NONE);
      5'd9:    o = mk(SEL_TV0, SEL_E12, 1'b1, 1'b0, DST_QV1);
      5'd10:   o = mk(SEL_TV0, SEL_E11, 1'b0, 1'b1, DST_NONE);
      5'd11:   o = mk(SEL_TV1, SEL_E10, 1'b1, 1'b0, DST_QV2);
      5'd12:   o = mk(SEL_E10, SEL_PV0, 1'b0, 1'b1, DST_NONE);
      5'd13:   o = mk(SEL_E11, SEL_PV1, 1'b0, 1'b0, DST_NONE);
      5'd14:   o = mk(SEL_E12, SEL_PV2, 1'b0, 1'b0, DST_DET);
      5'd15:   o = mk(SEL_TV0, SEL_PV0, 1'b0, 1'b1, DST_NONE);
      5'd16:   o = mk(SEL_TV1, SEL_PV1, 1'b0, 1'b0, DST_NONE);
      5'd17:   o = mk(SEL_TV2, SEL_PV2, 1'b0, 1'b0, DST_U);
      5'd18:   o = mk(SEL_D0,  SEL_QV0, 1'b0, 1'b1, DST_NONE);
      5'd19:   o = mk(SEL_D1,  SEL_QV1, 1'b0, 1'b0, DST_NONE);
      5'd20:   o = mk(SEL_D2,  SEL_QV2, 1'b0, 1'b0, DST_V);
      5'd21:   o = mk(SEL_E20, SEL_QV0, 1'b0, 1'b1, DST_NONE);
      5'd22:   o = mk(SEL_E21, SEL_QV1, 1'b0, 1'b0, DST_NONE);
      5'd23:   o = mk(SEL_E22, SEL_QV2, 1'b0, 1'b0, DST_T);
      default: o = mk(SEL_D0,  SEL_D0,  1'b0, 1'b1, DST_NONE);
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ray_triangle_closest_hit.sv
// Top level of the closest-hit ray/triangle intersection unit.
// Usage:
//   The input channel carries one beat per item. A ray beat (cmd 0) gives the
//   segment origin in a and its extremity in b; it clears the best hit and
//   gives no result. A triangle beat (cmd 1) gives vertices a, b, c and a tag,
//   and is tested exactly against the current segment; a hit is kept when it
//   is no farther than the best so far. A triangle beat with last set gives
//   one result beat: found, t, u, v and tag of the closest hit.
//   A ray beat is taken while the engine is idle. A triangle runs the serial
//   multiply-accumulate on the single shared bit-serial multiplier, then the
//   sign fix and tests and up to three restoring divisions.
//   A front register and a two-entry queue accept further beats while the
//   engine works. When the receiver stalls, the result holds in the output
//   register and the engine waits only when a further result is ready.
//   After reset the segment is zero, so triangles miss until a ray arrives;
//   best t is one and no result is pending.
`timescale 1ns / 1ps
`default_nettype none
module ray_triangle_closest_hit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        cmd_i,
  input  wire logic [31:0] ax_i,
  input  wire logic [31:0] ay_i,
  input  wire logic [31:0] az_i,
  input  wire logic [31:0] bx_i,
  input  wire logic [31:0] by_i,
  input  wire logic [31:0] bz_i,
  input  wire logic [31:0] cx_i,
  input  wire logic [31:0] cy_i,
  input  wire logic [31:0] cz_i,
  input  wire logic [31:0] tag_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             found_o,
  output logic [16:0]      hit_t_o,
  output logic [16:0]      hit_u_o,
  output logic [16:0]      hit_v_o,
  output logic [31:0]      hit_tag_o
);
  import rtc_pkg::*;

  logic  f_valid, f_ready, q_valid, q_ready;
  item_t f_item, q_item;

  rtc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .cmd_i, .ax_i, .ay_i, .az_i, .bx_i, .by_i, .bz_i, .cx_i, .cy_i, .cz_i,
    .tag_i, .last_i,
    .f_valid_o (f_valid),
    .f_item_o  (f_item),
    .f_ready_i (f_ready)
  );

  rtc_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i (f_valid),
    .wr_item_i  (f_item),
    .wr_ready_o (f_ready),
    .rd_valid_o (q_valid),
    .rd_item_o  (q_item),
    .rd_ready_i (q_ready)
  );

  rtc_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_ready_o (q_ready),
    .out_valid_o, .out_ready_i,
    .found_o, .hit_t_o, .hit_u_o, .hit_v_o, .hit_tag_o
  );

endmodule
`default_nettype wire

FILE: hw/rtl/rtc_front.sv
// Front stage: takes input beats, forms the edge vectors and registers them.
`timescale 1ns / 1ps
`default_nettype none
module rtc_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        cmd_i,
  input  wire logic [31:0]                 ax_i,
  input  wire logic [31:0]                 ay_i,
  input  wire logic [31:0]                 az_i,
  input  wire logic [31:0]                 bx_i,
  input  wire logic [31:0]                 by_i,
  input  wire logic [31:0]                 bz_i,
  input  wire logic [31:0]                 cx_i,
  input  wire logic [31:0]                 cy_i,
  input  wire logic [31:0]                 cz_i,
  input  wire logic [31:0]                 tag_i,
  input  wire logic                        last_i,
  output logic                             f_valid_o,
  output rtc_pkg::item_t                   f_item_o,
  input  wire logic                        f_ready_i
);
  import rtc_pkg::*;

  logic  valid_q;
  item_t item_q;
  item_t item_d;
  logic  [2:0][COORD_W-1:0] a_c, b_c, c_c;

  assign in_ready_o = !valid_q || f_ready_i;
  assign f_valid_o  = valid_q;
  assign f_item_o   = item_q;

  // Edge vectors b - a and c - a, exact in one extra bit.
  always_comb begin
    a_c = {az_i[COORD_W-1:0], ay_i[COORD_W-1:0], ax_i[COORD_W-1:0]};
    b_c = {bz_i[COORD_W-1:0], by_i[COORD_W-1:0], bx_i[COORD_W-1:0]};
    c_c = {cz_i[COORD_W-1:0], cy_i[COORD_W-1:0], cx_i[COORD_W-1:0]};
    item_d.cmd  = cmd_i;
    item_d.last = last_i;
    item_d.tag  = tag_i[TAG_W-1:0];
    item_d.pa   = a_c;
    for (int i = 0; i < 3; i++) begin
      item_d.q1[i] = {b_c[i][COORD_W-1], b_c[i]} - {a_c[i][COORD_W-1], a_c[i]};
      item_d.q2[i] = {c_c[i][COORD_W-1], c_c[i]} - {a_c[i][COORD_W-1], a_c[i]};
    end
  end

  // Stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/rtc_queue.sv
// Two-entry queue between the front stage and the intersection engine.
`timescale 1ns / 1ps
`default_nettype none
module rtc_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_valid_i,
  input  wire rtc_pkg::item_t wr_item_i,
  output logic                wr_ready_o,
  output logic                rd_valid_o,
  output rtc_pkg::item_t      rd_item_o,
  input  wire logic           rd_ready_i
);
  import rtc_pkg::*;

  item_t mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic push, pop;

  assign wr_ready_o = cnt_q != QCNT_W'(QDEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= wr_item_i;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/rtc_back.sv
// Intersection engine: serial multiply-accumulate, sign fix, tests and divisions.
`timescale 1ns / 1ps
`default_nettype none
module rtc_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_valid_i,
  input  wire rtc_pkg::item_t q_item_i,
  output logic                q_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic                found_o,
  output logic [16:0]         hit_t_o,
  output logic [16:0]         hit_u_o,
  output logic [16:0]         hit_v_o,
  output logic [31:0]         hit_tag_o
);
  import rtc_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LOAD  = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_FIX   = 8'b0000_1000,
    S_CHECK = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_FIN   = 8'b0100_0000,
    S_UNUSED = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [COORD_W-1:0] org_q [3];
  logic [NW-1:0]      dir_q [3];
  logic [NW-1:0]      e1_q  [3];
  logic [NW-1:0]      e2_q  [3];
  logic [NW-1:0]      tv_q  [3];
  logic [CW-1:0]      pv_q  [3];
  logic [CW-1:0]      qv_q  [3];
  logic signed [AW-1:0] det_q, u_q, v_q, t_q, acc_q, mcand_q;
  logic [NW-1:0]      mplier_q;
  logic [OP_W-1:0]    op_idx_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [AW-1:0]      x_q, dv_q;
  logic [QW-1:0]      quo_q, tq_q, uq_q;
  logic [1:0]         dsel_q;
  logic               last_q;
  logic [TAG_W-1:0]   tag_q;
  logic [QW-1:0]      best_t_q, best_u_q, best_v_q;
  logic [TAG_W-1:0]   best_tag_q;
  logic               hit_q;
  logic               out_valid_q;

  op_t                op;
  logic [NW-1:0]      a_val;
  logic signed [AW-1:0] b_val, acc_step, uv_sum;
  logic               neg_term, mul_done, div_done, ge, pass, slot_free;
  logic [AW-1:0]      x_sub;
  logic [QW-1:0]      qn;

  assign op        = op_rom(op_idx_q);
  assign q_ready_o = state_q == S_IDLE;
  assign slot_free = !out_valid_q || out_ready_i;
  assign mul_done  = cnt_q == CNT_W'(NW - 1);
  assign div_done  = cnt_q == CNT_W'(FRAC_BITS);

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (op.a_sel)
      SEL_D0:  a_val = dir_q[0];
      SEL_D1:  a_val = dir_q[1];
      SEL_D2:  a_val = dir_q[2];
      SEL_E10: a_val = e1_q[0];
      SEL_E11: a_val = e1_q[1];
      SEL_E12: a_val = e1_q[2];
      SEL_E20: a_val = e2_q[0];
      SEL_E21: a_val = e2_q[1];
      SEL_E22: a_val = e2_q[2];
      SEL_TV0: a_val = tv_q[0];
      SEL_TV1: a_val = tv_q[1];
      SEL_TV2: a_val = tv_q[2];
      default: a_val = '0;
    endcase
    unique case (op.b_sel)
      SEL_E20: b_val = {{(AW-NW){e2_q[0][NW-1]}}, e2_q[0]};
      SEL_E21: b_val = {{(AW-NW){e2_q[1][NW-1]}}, e2_q[1]};
      SEL_E22: b_val = {{(AW-NW){e2_q[2][NW-1]}}, e2_q[2]};
      SEL_E10: b_val = {{(AW-NW){e1_q[0][NW-1]}}, e1_q[0]};
      SEL_E11: b_val = {{(AW-NW){e1_q[1][NW-1]}}, e1_q[1]};
      SEL_E12: b_val = {{(AW-NW){e1_q[2][NW-1]}}, e1_q[2]};
      SEL_PV0: b_val = {{(AW-CW){pv_q[0][CW-1]}}, pv_q[0]};
      SEL_PV1: b_val = {{(AW-CW){pv_q[1][CW-1]}}, pv_q[1]};
      SEL_PV2: b_val = {{(AW-CW){pv_q[2][CW-1]}}, pv_q[2]};
      SEL_QV0: b_val = {{(AW-CW){qv_q[0][CW-1]}}, qv_q[0]};
      SEL_QV1: b_val = {{(AW-CW){qv_q[1][CW-1]}}, qv_q[1]};
      SEL_QV2: b_val = {{(AW-CW){qv_q[2][CW-1]}}, qv_q[2]};
      default: b_val = '0;
    endcase
  end

  // One multiplier bit per cycle; the sign bit of a carries negative weight.
  always_comb begin
    neg_term = op.sub ^ mul_done;
    if (!mplier_q[0]) begin
      acc_step = acc_q;
    end else if (neg_term) begin
      acc_step = acc_q - mcand_q;
    end else begin
      acc_step = acc_q + mcand_q;
    end
  end

  // Hit tests on the sign-corrected values, and one restoring division step.
  always_comb begin
    uv_sum = u_q + v_q;
    pass   = (det_q != '0) && !u_q[AW-1] && (u_q <= det_q) && !v_q[AW-1] &&
             (uv_sum <= det_q) && !t_q[AW-1] && (t_q <= det_q);
    ge     = x_q >= dv_q;
    x_sub  = ge ? (x_q - dv_q) : x_q;
    qn     = {quo_q[QW-2:0], ge};
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i && q_item_i.cmd != CMD_RAY) state_d = S_LOAD;
      end
      S_LOAD:  state_d = S_MUL;
      S_MUL: begin
        if (mul_done) state_d = (op_idx_q == OP_W'(NOPS - 1)) ? S_FIX : S_LOAD;
      end
      S_FIX:   state_d = S_CHECK;
      S_CHECK: state_d = pass ? S_DIV : S_FIN;
      S_DIV: begin
        if (div_done) begin
          if (dsel_q == DIV_V || (dsel_q == DIV_T && qn > best_t_q)) state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!last_q || slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      best_t_q    <= ONE_Q;
      best_u_q    <= '0;
      best_v_q    <= '0;
      best_tag_q  <= '0;
      hit_q       <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        org_q[i] <= '0;
        dir_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      // A new result beat replaces the one taken in the same cycle.
      if (state_q == S_FIN && last_q && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // A ray beat loads the segment and clears the best hit.
      if (state_q == S_IDLE && q_valid_i && q_item_i.cmd == CMD_RAY) begin
        for (int i = 0; i < 3; i++) begin
          org_q[i] <= q_item_i.pa[i];
          dir_q[i] <= q_item_i.q1[i];
        end
        best_t_q   <= ONE_Q;
        best_u_q   <= '0;
        best_v_q   <= '0;
        best_tag_q <= '0;
        hit_q      <= 1'b0;
      end
      // Closest hit so far, with the later triangle winning a tie.
      if (state_q == S_DIV && div_done && dsel_q == DIV_V) begin
        best_t_q   <= tq_q;
        best_u_q   <= uq_q;
        best_v_q   <= qn;
        best_tag_q <= tag_q;
        hit_q      <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i && q_item_i.cmd != CMD_RAY) begin
          for (int i = 0; i < 3; i++) begin
            e1_q[i] <= q_item_i.q1[i];
            e2_q[i] <= q_item_i.q2[i];
            tv_q[i] <= {org_q[i][COORD_W-1], org_q[i]} -
                       {q_item_i.pa[i][COORD_W-1], q_item_i.pa[i]};
          end
          tag_q    <= q_item_i.tag;
          last_q   <= q_item_i.last;
          op_idx_q <= '0;
        end
      end
      S_LOAD: begin
        mcand_q  <= b_val;
        mplier_q <= a_val;
        cnt_q    <= '0;
        if (op.first) acc_q <= '0;
      end
      S_MUL: begin
        acc_q    <= acc_step;
        mcand_q  <= mcand_q <<< 1;
        mplier_q <= mplier_q >> 1;
        cnt_q    <= cnt_q + 1'b1;
        if (mul_done) begin
          op_idx_q <= op_idx_q + 1'b1;
          unique case (op.dst)
            DST_PV0: pv_q[0] <= acc_step[CW-1:0];
            DST_PV1: pv_q[1] <= acc_step[CW-1:0];
            DST_PV2: pv_q[2] <= acc_step[CW-1:0];
            DST_QV0: qv_q[0] <= acc_step[CW-1:0];
            DST_QV1: qv_q[1] <= acc_step[CW-1:0];
            DST_QV2: qv_q[2] <= acc_step[CW-1:0];
            DST_DET: det_q   <= acc_step;
            DST_U:   u_q     <= acc_step;
            DST_V:   v_q     <= acc_step;
            DST_T:   t_q     <= acc_step;
            default: ;
          endcase
        end
      end
      S_FIX: begin
        if (det_q[AW-1]) begin
          det_q <= -det_q;
          u_q   <= -u_q;
          v_q   <= -v_q;
          t_q   <= -t_q;
        end
      end
      S_CHECK: begin
        x_q    <= t_q;
        dv_q   <= det_q;
        quo_q  <= '0;
        cnt_q  <= '0;
        dsel_q <= DIV_T;
      end
      S_DIV: begin
        if (div_done) begin
          // The quotient is complete; start on the next numerator.
          quo_q <= '0;
          cnt_q <= '0;
          unique case (dsel_q)
            DIV_T: begin
              tq_q   <= qn;
              x_q    <= u_q;
              dsel_q <= DIV_U;
            end
            DIV_U: begin
              uq_q   <= qn;
              x_q    <= v_q;
              dsel_q <= DIV_V;
            end
            default: ;
          endcase
        end else begin
          quo_q <= qn;
          cnt_q <= cnt_q + 1'b1;
          x_q   <= x_sub << 1;
        end
      end
      S_FIN: begin
        if (last_q && slot_free) begin
          found_o   <= hit_q;
          hit_t_o   <= best_t_q;
          hit_u_o   <= best_u_q;
          hit_v_o   <= best_v_q;
          hit_tag_o <= best_tag_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

FILE: hw/rtl/rtc_checker.sv
// Port-level checks of the closest-hit unit and their binding.
`timescale 1ns / 1ps
`default_nettype none
module rtc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        found_o,
  input wire logic [16:0] hit_t_o,
  input wire logic [16:0] hit_u_o,
  input wire logic [16:0] hit_v_o,
  input wire logic [31:0] hit_tag_o
);

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_t_o) &&
    $stable(hit_tag_o) && $stable(found_o))
    else $error("result beat changed while stalled");

  // A miss reports the cleared best hit.
  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> hit_t_o == 17'd65536 && hit_u_o == 17'd0 &&
    hit_v_o == 17'd0 && hit_tag_o == 32'd0)
    else $error("miss result is not cleared");

  // Barycentrics of a hit stay inside the triangle.
  a_bary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> ({1'b0, hit_u_o} + {1'b0, hit_v_o}) <= 18'd65536)
    else $error("u + v beyond one");

  // The distance never exceeds the segment.
  a_tmax: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hit_t_o <= 17'd65536)
    else $error("t beyond segment end");

endmodule

bind ray_triangle_closest_hit rtc_checker u_rtc_checker (.*);
`default_nettype wire
